FILE: sv/tlbmmu_pkg.sv
// ----------------------------------------------------------------------------
// tlbmmu_pkg
// Shared types and constants for the paging MMU with an LRU-replaced TLB.
// ----------------------------------------------------------------------------
package tlbmmu_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TLB_SCAN,
        ST_PT_READ,
        ST_PT_WAIT,
        ST_FRAME_SCAN,
        ST_EVICT,
        ST_TLB_VICTIM,
        ST_UPDATE,
        ST_OUTPUT
    } seq_state_t;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_MEMORY_TIME = 2'd0;
    localparam logic [1:0] REG_TLB_TIME    = 2'd1;
    localparam logic [1:0] REG_FAULT_TIME  = 2'd2;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // Operation code for a write access
    localparam logic OP_WRITE = 1'b1;

    // Result of one stamp compare step
    typedef struct packed {
        logic is_zero;
        logic less;
    } cmp_result_t;

endpackage

FILE: sv/tlb_page_table_lru_mmu_unit.sv
// ----------------------------------------------------------------------------
// tlb_page_table_lru_mmu_unit
// Demand paging MMU: TLB lookup, page table, LRU frame and TLB replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries virtual_address and op.
//   Output channel (out_valid/out_ready) returns one result per access:
//   frame, hit/fault/write back flags, access time and running totals.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   memory_time (0), tlb_time (1), fault_time (2); other indexes ignored.
//   One access at a time. A TLB hit ends the TLB scan early; a
//   miss adds a page table read and a TLB victim scan, and a fault
//   adds a scan of up to 16 frames and an evict step.
//   All stamp compares go through one shared stamp comparator, one element a
//   cycle; the page table is a memory with a registered read port.
//   Reset clears the TLB, frame records and page table valid bits at once
//   (no clearing pass), time counter to one, totals to zero.
//   The result waits in an output register while out_ready is low; in_ready
//   stays low until that transfer completes.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_mmu_unit
#(
    parameter int TLB_ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] virtual_address,
    input  logic        op,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  frame_number,
    output logic        tlb_hit,
    output logic        page_fault,
    output logic        wrote_back,
    output logic [17:0] access_time,
    output logic [31:0] event_count,
    output logic [31:0] hit_count,
    output logic [31:0] page_in_count,
    output logic [31:0] page_out_count,
    output logic [47:0] total_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tlbmmu_pkg::*;

    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CW = $clog2(TLB_ENTRIES + 1) > 4 ? $clog2(TLB_ENTRIES + 1) : 5;

    seq_state_t state_reg, state_next;

    // Configuration registers
    logic [15:0] memory_time_reg, tlb_time_reg, fault_time_reg;

    // TLB
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [6:0]  tlb_page_reg  [TLB_ENTRIES];
    logic [3:0]  tlb_frame_reg [TLB_ENTRIES];
    logic [31:0] tlb_stamp_reg [TLB_ENTRIES];

    // Page table: valid bits in flops, frame numbers in a memory
    logic [127:0] page_valid_reg;
    logic [3:0]   page_mem [128];
    logic [3:0]   pt_rdata_reg;

    // Frame records
    logic [15:0] frame_used_reg, frame_dirty_reg;
    logic [6:0]  frame_page_reg  [16];
    logic [31:0] frame_stamp_reg [16];

    // Counters
    logic [31:0] time_counter_reg, hits_total_reg, page_ins_reg, page_outs_reg;
    logic [47:0] time_total_reg;

    // Per access working registers
    logic [6:0]  page_reg;
    logic        write_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] least_reg;
    logic [3:0]  frame_reg;
    logic [TW-1:0] tvict_reg;
    logic        hit_reg, fault_reg, wb_reg;
    logic [17:0] acc_reg;

    // Output register
    logic        out_valid_reg;
    logic [3:0]  o_frame_reg;
    logic        o_hit_reg, o_fault_reg, o_wb_reg;
    logic [17:0] o_acc_reg;
    logic [31:0] o_event_reg;

    // Shared comparator
    logic [31:0] cmp_stamp;
    cmp_result_t cmp_res;
    logic [TW-1:0] tidx;
    logic [3:0]    fidx;
    assign tidx = idx_reg[TW-1:0];
    assign fidx = idx_reg[3:0];

    always_comb
    begin
        if (state_reg == ST_FRAME_SCAN)
            cmp_stamp = frame_stamp_reg[fidx];
        else
            cmp_stamp = tlb_stamp_reg[tidx];
    end

    tlbmmu_stamp_cmp u_cmp
    (
        .stamp  (cmp_stamp),
        .least  (least_reg),
        .result (cmp_res)
    );

    logic last_tlb;
    assign last_tlb = (idx_reg == CW'(TLB_ENTRIES - 1));
    logic tlb_match;
    assign tlb_match = tlb_valid_reg[tidx] && (tlb_page_reg[tidx] == page_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid && in_ready) state_next = ST_TLB_SCAN;
            ST_TLB_SCAN:
            begin
                if (tlb_match)     state_next = ST_UPDATE;
                else if (last_tlb) state_next = ST_PT_READ;
            end
            ST_PT_READ:    state_next = ST_PT_WAIT;
            ST_PT_WAIT:    state_next = page_valid_reg[page_reg] ? ST_TLB_VICTIM
                                                                 : ST_FRAME_SCAN;
            ST_FRAME_SCAN:
            begin
                if (!frame_used_reg[fidx] || idx_reg == CW'(15))
                    state_next = ST_EVICT;
            end
            ST_EVICT:      state_next = ST_TLB_VICTIM;
            ST_TLB_VICTIM:
            begin
                if (cmp_res.is_zero || last_tlb) state_next = ST_UPDATE;
            end
            ST_UPDATE:     state_next = ST_OUTPUT;
            ST_OUTPUT:     if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs; a new access waits until the last result is taken
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
        cfg_ready = (state_reg == ST_IDLE);
    end

    // Saturating sums used at the end of an access
    logic [48:0] tsum;
    assign tsum = {1'b0, time_total_reg} + 49'(acc_reg);

    // Datapath and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            memory_time_reg  <= '0;
            tlb_time_reg     <= '0;
            fault_time_reg   <= '0;
            tlb_valid_reg    <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_page_reg[i]  <= '0;
                tlb_frame_reg[i] <= '0;
                tlb_stamp_reg[i] <= '0;
            end
            page_valid_reg   <= '0;
            frame_used_reg   <= '0;
            frame_dirty_reg  <= '0;
            for (int i = 0; i < 16; i++)
            begin
                frame_page_reg[i]  <= '0;
                frame_stamp_reg[i] <= '0;
            end
            time_counter_reg <= 32'd1;
            hits_total_reg   <= '0;
            page_ins_reg     <= '0;
            page_outs_reg    <= '0;
            time_total_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        unique case (cfg_index)
                            REG_MEMORY_TIME: memory_time_reg <= cfg_data;
                            REG_TLB_TIME:    tlb_time_reg    <= cfg_data;
                            REG_FAULT_TIME:  fault_time_reg  <= cfg_data;
                            default: ;
                        endcase
                    end
                    if (in_valid && in_ready)
                    begin
                        page_reg  <= virtual_address[15:9];
                        write_reg <= op;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        fault_reg <= 1'b0;
                        wb_reg    <= 1'b0;
                        acc_reg   <= 18'(tlb_time_reg);
                    end
                end
                ST_TLB_SCAN:
                begin
                    if (tlb_match)
                    begin
                        hit_reg   <= 1'b1;
                        frame_reg <= tlb_frame_reg[tidx];
                        tlb_stamp_reg[tidx] <= time_counter_reg;
                        hits_total_reg <= (hits_total_reg == MAX32) ? MAX32
                                          : hits_total_reg + 32'd1;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_PT_READ:
                begin
                    acc_reg <= acc_reg + 18'(memory_time_reg);
                end
                ST_PT_WAIT:
                begin
                    idx_reg <= '0;
                    if (!page_valid_reg[page_reg])
                    begin
                        fault_reg <= 1'b1;
                        acc_reg   <= acc_reg + 18'(fault_time_reg);
                        frame_reg <= '0;
                        least_reg <= time_counter_reg;
                    end
                    else
                    begin
                        frame_reg <= pt_rdata_reg;
                        least_reg <= tlb_stamp_reg[0];
                        tvict_reg <= '0;
                    end
                end
                ST_FRAME_SCAN:
                begin
                    if (!frame_used_reg[fidx])
                        frame_reg <= fidx;
                    else if (cmp_res.less)
                    begin
                        least_reg <= cmp_stamp;
                        frame_reg <= fidx;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_EVICT:
                begin
                    if (frame_used_reg[frame_reg])
                    begin
                        if (frame_dirty_reg[frame_reg])
                        begin
                            wb_reg  <= 1'b1;
                            acc_reg <= acc_reg + 18'(fault_time_reg);
                            page_outs_reg <= (page_outs_reg == MAX32) ? MAX32
                                             : page_outs_reg + 32'd1;
                        end
                        page_valid_reg[frame_page_reg[frame_reg]] <= 1'b0;
                        for (int i = 0; i < TLB_ENTRIES; i++)
                        begin
                            if (tlb_valid_reg[i] &&
                                tlb_page_reg[i] == frame_page_reg[frame_reg])
                            begin
                                tlb_valid_reg[i] <= 1'b0;
                                tlb_stamp_reg[i] <= '0;
                            end
                        end
                    end
                    page_ins_reg <= (page_ins_reg == MAX32) ? MAX32
                                    : page_ins_reg + 32'd1;
                    frame_used_reg[frame_reg]  <= 1'b1;
                    frame_page_reg[frame_reg]  <= page_reg;
                    frame_dirty_reg[frame_reg] <= 1'b0;
                    page_valid_reg[page_reg]   <= 1'b1;
                    idx_reg   <= '0;
                    least_reg <= tlb_stamp_reg[0];
                    tvict_reg <= '0;
                end
                ST_TLB_VICTIM:
                begin
                    if (cmp_res.is_zero)
                        tvict_reg <= tidx;
                    else if (cmp_res.less)
                    begin
                        least_reg <= cmp_stamp;
                        tvict_reg <= tidx;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (cmp_res.is_zero || last_tlb)
                    begin
                        // Install takes the final pick of this cycle
                        tlb_valid_reg[cmp_res.is_zero ? tidx
                            : (cmp_res.less ? tidx : tvict_reg)] <= 1'b1;
                        tlb_page_reg[cmp_res.is_zero ? tidx
                            : (cmp_res.less ? tidx : tvict_reg)] <= page_reg;
                        tlb_frame_reg[cmp_res.is_zero ? tidx
                            : (cmp_res.less ? tidx : tvict_reg)] <= frame_reg;
                        tlb_stamp_reg[cmp_res.is_zero ? tidx
                            : (cmp_res.less ? tidx : tvict_reg)] <= time_counter_reg;
                    end
                end
                ST_UPDATE:
                begin
                    if (write_reg == OP_WRITE)
                        frame_dirty_reg[frame_reg] <= 1'b1;
                    frame_stamp_reg[frame_reg] <= time_counter_reg;
                    time_counter_reg <= (time_counter_reg == MAX32) ? MAX32
                                        : time_counter_reg + 32'd1;
                    time_total_reg <= tsum[48] ? MAX48
                                      : (tsum[47:0] > MAX48 ? MAX48 : tsum[47:0]);
                    o_frame_reg <= frame_reg;
                    o_hit_reg   <= hit_reg;
                    o_fault_reg <= fault_reg;
                    o_wb_reg    <= wb_reg;
                    o_acc_reg   <= acc_reg;
                    o_event_reg <= time_counter_reg;
                end
                ST_OUTPUT:
                begin
                    if (!out_valid_reg || out_ready)
                        out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Page table frame memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVICT)
            page_mem[page_reg] <= frame_reg;
        pt_rdata_reg <= page_mem[page_reg];
    end

    // Result ports
    assign out_valid      = out_valid_reg;
    assign frame_number   = o_frame_reg;
    assign tlb_hit        = o_hit_reg;
    assign page_fault     = o_fault_reg;
    assign wrote_back     = o_wb_reg;
    assign access_time    = o_acc_reg;
    assign event_count    = o_event_reg;
    assign hit_count      = hits_total_reg;
    assign page_in_count  = page_ins_reg;
    assign page_out_count = page_outs_reg;
    assign total_time     = time_total_reg;

endmodule

FILE: sv/tlbmmu_stamp_cmp.sv
// ----------------------------------------------------------------------------
// tlbmmu_stamp_cmp
// Shared stamp comparator used by both the TLB and the frame victim scans.
// ----------------------------------------------------------------------------
module tlbmmu_stamp_cmp
(
    input  logic [31:0]             stamp,
    input  logic [31:0]             least,
    output tlbmmu_pkg::cmp_result_t result
);
    import tlbmmu_pkg::*;

    // One compare per cycle; the sequencer feeds the element under scan
    always_comb
    begin
        result.is_zero = (stamp == 32'd0);
        result.less    = (stamp < least);
    end

endmodule
